### src/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared widths, datapath command encodings and the controller-to-datapath
// command word for the stereo biquad filter.
// ----------------------------------------------------------------------------
package sbq_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 32;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int PROD_SHIFT = 13;
	localparam int TERM_W     = PROD_W - PROD_SHIFT;
	localparam int STATE_W    = 48;
	localparam int ACC_W      = STATE_W + 2;
	localparam int ROUND_SH   = 16;
	localparam int CFG_IDX_W  = 3;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_XB0,
		MUL_XB1,
		MUL_XB2,
		MUL_YA1,
		MUL_YA2
	} mul_sel_t;

	// accumulator updates
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_P_D1,
		ACC_P_D2,
		ACC_P,
		ACC_SUB_P
	} acc_op_t;

	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     y_ld;
		logic     d1_wr;
		logic     d2_wr;
		logic     out_ld;
	} sbq_cmd_t;

endpackage

### src/sbq_in_if.sv
// ----------------------------------------------------------------------------
// sbq_in_if
// Input sample stream: valid/ready handshake, one sample word per transfer.
// ----------------------------------------------------------------------------
interface sbq_in_if;
	import sbq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       chan;

	modport source (output valid, output sample_in, output chan, input ready);
	modport sink   (input valid, input sample_in, input chan, output ready);

endinterface

### src/sbq_out_if.sv
// ----------------------------------------------------------------------------
// sbq_out_if
// Output sample stream: valid/ready handshake, one filtered word per transfer.
// ----------------------------------------------------------------------------
interface sbq_out_if;
	import sbq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       chan_out;

	modport source (output valid, output sample_out, output chan_out, input ready);
	modport sink   (input valid, input sample_out, input chan_out, output ready);

endinterface

### src/sbq_ctrl.sv
// ----------------------------------------------------------------------------
// sbq_ctrl
// Sequencer for one biquad update: steps the shared multiplier through the
// five products and hands the result to the output register.
// ----------------------------------------------------------------------------
module sbq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sbq_pkg::sbq_cmd_t cmd
);
	import sbq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MB0,
		ST_Y,
		ST_SAT,
		ST_MA1,
		ST_MB2,
		ST_MA2,
		ST_FIN,
		ST_WB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   wb_go;

	assign wb_go     = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_XB0;
		cmd.acc_op  = ACC_HOLD;
		unique case (state_q)
			ST_IDLE: cmd.load_in = in_valid;
			ST_MB0:  cmd.mul_sel = MUL_XB0;
			ST_Y:    cmd.acc_op  = ACC_P_D1;
			ST_SAT: begin
				cmd.y_ld    = 1'b1;
				cmd.mul_sel = MUL_XB1;
			end
			ST_MA1: begin
				cmd.acc_op  = ACC_P_D2;
				cmd.mul_sel = MUL_YA1;
			end
			ST_MB2: begin
				cmd.acc_op  = ACC_SUB_P;
				cmd.mul_sel = MUL_XB2;
			end
			ST_MA2: begin
				cmd.d1_wr   = 1'b1;
				cmd.acc_op  = ACC_P;
				cmd.mul_sel = MUL_YA2;
			end
			ST_FIN:  cmd.acc_op = ACC_SUB_P;
			ST_WB: begin
				cmd.d2_wr  = wb_go;
				cmd.out_ld = wb_go;
			end
			default: cmd.acc_op = ACC_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_MB0;
				ST_MB0:  state_q <= ST_Y;
				ST_Y:    state_q <= ST_SAT;
				ST_SAT:  state_q <= ST_MA1;
				ST_MA1:  state_q <= ST_MB2;
				ST_MB2:  state_q <= ST_MA2;
				ST_MA2:  state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_WB;
				ST_WB:   if (wb_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_WB && wb_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/sbq_datapath.sv
// ----------------------------------------------------------------------------
// sbq_datapath
// Coefficient registers, per-channel delay state, one shared 24x32
// multiplier, the 50-bit accumulator, rounding/saturation and output word.
// ----------------------------------------------------------------------------
module sbq_datapath #(
	parameter int CHANNELS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbq_pkg::sbq_cmd_t                   cmd,
	input  logic                                cfg_we,
	input  logic [sbq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sbq_pkg::COEF_W-1:0]          cfg_wdata,
	input  logic signed [sbq_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                chan,
	output logic signed [sbq_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                chan_out
);
	import sbq_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);

	localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(536870912);

	logic signed [COEF_W-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [STATE_W-1:0]  d1_q [CHANNELS];
	logic signed [STATE_W-1:0]  d2_q [CHANNELS];

	logic signed [SAMPLE_W-1:0] x_q, y_q;
	logic                       chan_q, ch_ok_q;
	logic signed [PROD_W-1:0]   p_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_chan_q;

	logic [IDX_W-1:0]             rd_idx;
	logic signed [SAMPLE_W-1:0]   op_a;
	logic signed [COEF_W-1:0]     op_b;
	logic signed [PROD_W-1:0]     prod;
	logic signed [TERM_W-1:0]     term;
	logic signed [ACC_W-1:0]      term_x;
	logic signed [ACC_W-1:0]      d1_x, d2_x;
	logic signed [ACC_W-1:0]      rnd;
	logic signed [ACC_W-ROUND_SH-1:0] rnd_sh;
	logic signed [SAMPLE_W-1:0]   y_sat;
	logic signed [STATE_W-1:0]    st_sat;

	// out-of-range channels read entry 0 and never write
	assign rd_idx = ch_ok_q ? IDX_W'(chan_q) : '0;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_XB0: begin op_a = x_q; op_b = b0_q; end
			MUL_XB1: begin op_a = x_q; op_b = b1_q; end
			MUL_XB2: begin op_a = x_q; op_b = b2_q; end
			MUL_YA1: begin op_a = y_q; op_b = a1_q; end
			MUL_YA2: begin op_a = y_q; op_b = a2_q; end
			default: begin op_a = x_q; op_b = b0_q; end
		endcase
	end

	assign prod   = PROD_W'(op_a) * PROD_W'(op_b);
	// dropping low bits of a two's complement value is a floor shift
	assign term   = p_q[PROD_W-1:PROD_SHIFT];
	assign term_x = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
	assign d1_x   = {{(ACC_W-STATE_W){d1_q[rd_idx][STATE_W-1]}}, d1_q[rd_idx]};
	assign d2_x   = {{(ACC_W-STATE_W){d2_q[rd_idx][STATE_W-1]}}, d2_q[rd_idx]};

	// round half up, then clamp to the 24-bit range
	assign rnd    = acc_q + ACC_W'(32768);
	assign rnd_sh = rnd[ACC_W-1:ROUND_SH];

	always_comb begin
		if (rnd_sh[ACC_W-ROUND_SH-1:SAMPLE_W-1] == '0 ||
		    rnd_sh[ACC_W-ROUND_SH-1:SAMPLE_W-1] == '1) begin
			y_sat = rnd_sh[SAMPLE_W-1:0];
		end else if (rnd_sh[ACC_W-ROUND_SH-1]) begin
			y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_comb begin
		if (acc_q[ACC_W-1:STATE_W-1] == '0 || acc_q[ACC_W-1:STATE_W-1] == '1) begin
			st_sat = acc_q[STATE_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			st_sat = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			st_sat = {1'b0, {(STATE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= B0_RESET;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0:  b0_q <= cfg_wdata;
				REG_B1:  b1_q <= cfg_wdata;
				REG_B2:  b2_q <= cfg_wdata;
				REG_A1:  a1_q <= cfg_wdata;
				REG_A2:  a2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else begin
			if (cmd.d1_wr && ch_ok_q) d1_q[rd_idx] <= st_sat;
			if (cmd.d2_wr && ch_ok_q) d2_q[rd_idx] <= st_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q     <= sample_in;
			chan_q  <= chan;
			ch_ok_q <= (CHANNELS > 1) || !chan;
		end
		p_q <= prod;
		unique case (cmd.acc_op)
			ACC_P_D1:  acc_q <= term_x + d1_x;
			ACC_P_D2:  acc_q <= term_x + d2_x;
			ACC_P:     acc_q <= term_x;
			ACC_SUB_P: acc_q <= acc_q - term_x;
			default:   acc_q <= acc_q;
		endcase
		if (cmd.y_ld) y_q <= y_sat;
		if (cmd.out_ld) begin
			out_sample_q <= ch_ok_q ? y_q : '0;
			out_chan_q   <= chan_q;
		end
	end

	assign sample_out = out_sample_q;
	assign chan_out   = out_chan_q;

endmodule

### src/stereo_biquad_filter_core.sv
// ----------------------------------------------------------------------------
// stereo_biquad_filter_core
// Two-channel transposed direct form II biquad with shared Q2.29 coefficients.
//
//   port   dir   handshake     word
//   din    in    valid/ready   sample_in[23:0], chan
//   dout   out   valid/ready   sample_out[23:0], chan_out
//   cfg    in    cfg_we only   cfg_index[2:0], cfg_wdata[31:0]
//
// A sample is accepted from idle; the single shared multiplier then runs the five
// products in sequence, followed by the round/clamp steps, before the result is
// valid in the output register.
// A new sample is accepted once the previous one has reached the output
// register; a stalled dout holds the core in write-back until it drains.
// Reset clears the delay state of every channel and loads default coefficients.
// ----------------------------------------------------------------------------
module stereo_biquad_filter_core #(
	parameter int CHANNELS = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sbq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbq_pkg::COEF_W-1:0]    cfg_wdata,
	sbq_in_if.sink                        din,
	sbq_out_if.source                     dout
);
	import sbq_pkg::*;

	sbq_cmd_t cmd;

	sbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.cmd       (cmd)
	);

	sbq_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (din.sample_in),
		.chan       (din.chan),
		.sample_out (dout.sample_out),
		.chan_out   (dout.chan_out)
	);

`ifndef ASSERT_OFF
	// a word is loaded only from the idle state, and then the core is busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> !din.ready)
		else $error("input accepted twice in a row");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!dout.valid || dout.ready))
		else $error("output word overwritten");

	// second delay write-back coincides with handing the word out
	a_wb_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.d2_wr |-> cmd.out_ld)
		else $error("state written without result");

	// loading an input and writing state never overlap
	a_load_vs_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |-> !(cmd.d1_wr || cmd.d2_wr || cmd.out_ld))
		else $error("input load during write-back");
`endif

endmodule
